### sv/rover_table_nearest_match_top_assert.svh
// Assertion macros for the rover table.
// Both sample on clk and are disabled while rst_n is low.
`ifndef ROVER_TABLE_NEAREST_MATCH_TOP_ASSERT_SVH
`define ROVER_TABLE_NEAREST_MATCH_TOP_ASSERT_SVH

// Same-cycle implication.
`define RTNM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RTNM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rtnm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtnm_pkg
// Shared constants, types and codes for the rover table with nearest match.
// ----------------------------------------------------------------------------
package rtnm_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 32;
    localparam int COORD_W     = 34;
    localparam int PROX_W      = 24;
    localparam int SQ_W        = 2 * PROX_W;
    localparam int DIST_W      = SQ_W + 2;
    localparam int SLOT_W      = 5;
    localparam int STATUS_W    = 4;
    localparam int ENTRY_W     = ID_W + 3 * COORD_W;

    localparam logic [PROX_W-1:0] PROX_RESET = PROX_W'(2500000);
    localparam logic [DIST_W-1:0] DIST_FAR   = '1;

    typedef enum logic [STATUS_W-1:0] {
        ST_REJECTED   = 4'd0,
        ST_UPDATED    = 4'd1,
        ST_REANCHORED = 4'd2,
        ST_JOINED     = 4'd3,
        ST_RECYCLED   = 4'd4,
        ST_APPENDED   = 4'd5,
        ST_FULL       = 4'd6,
        ST_DELETED    = 4'd7,
        ST_ABSENT     = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } entry_t;

    // Per-entry tag carried down the distance pipeline
    typedef struct packed {
        logic               vld;
        logic [IDX_W-1:0]   idx;
        logic               match;
        logic               free;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } tag_t;

endpackage

### sv/rtnm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtnm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rtnm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/rtnm_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtnm_dist
// Three-stage squared distance pipeline: axis magnitude and far check,
// per-axis square, then sum with far saturation.
// ----------------------------------------------------------------------------
module rtnm_dist
    import rtnm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_vld,
    input  logic [IDX_W-1:0]    rd_idx,
    input  entry_t              rd_entry,
    input  logic [ID_W-1:0]     req_id,
    input  logic [COORD_W-1:0]  req_x,
    input  logic [COORD_W-1:0]  req_y,
    input  logic [COORD_W-1:0]  req_z,
    input  logic [PROX_W-1:0]   prox,
    output tag_t                res_tag,
    output logic [DIST_W-1:0]   res_dist,
    output logic                busy
);

    tag_t               t1;
    logic [COORD_W:0]   mx, my, mz;
    logic               far1;

    tag_t               t2_reg, t3_reg, t4_reg;
    logic [PROX_W-1:0]  mx_reg, my_reg, mz_reg;
    logic               far2_reg, far3_reg;
    logic [SQ_W-1:0]    sqx_reg, sqy_reg, sqz_reg;
    logic [DIST_W-1:0]  dist_reg;

    function automatic logic [COORD_W:0] axis_mag(logic [COORD_W-1:0] a,
                                                  logic [COORD_W-1:0] b);
        logic [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d[COORD_W] ? (~d + 1'b1) : d;
    endfunction

    // Stage 1: tag the entry and take axis magnitudes
    always_comb
    begin
        t1.vld   = rd_vld;
        t1.idx   = rd_idx;
        t1.match = (rd_entry.id == req_id);
        t1.free  = (rd_entry.id == '0);
        t1.x     = rd_entry.x;
        t1.y     = rd_entry.y;
        t1.z     = rd_entry.z;
        mx       = axis_mag(req_x, rd_entry.x);
        my       = axis_mag(req_y, rd_entry.y);
        mz       = axis_mag(req_z, rd_entry.z);
        far1     = (mx > (COORD_W+1)'(prox)) || (my > (COORD_W+1)'(prox))
                || (mz > (COORD_W+1)'(prox));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t2_reg <= '0;
            t3_reg <= '0;
            t4_reg <= '0;
        end
        else
        begin
            t2_reg <= t1;
            t3_reg <= t2_reg;
            t4_reg <= t3_reg;
        end
    end

    // Datapath stages: magnitudes, squares, saturated sum
    always_ff @(posedge clk)
    begin
        mx_reg   <= mx[PROX_W-1:0];
        my_reg   <= my[PROX_W-1:0];
        mz_reg   <= mz[PROX_W-1:0];
        far2_reg <= far1;
        sqx_reg  <= SQ_W'(mx_reg) * SQ_W'(mx_reg);
        sqy_reg  <= SQ_W'(my_reg) * SQ_W'(my_reg);
        sqz_reg  <= SQ_W'(mz_reg) * SQ_W'(mz_reg);
        far3_reg <= far2_reg;
        dist_reg <= far3_reg ? DIST_FAR
                  : (DIST_W'(sqx_reg) + DIST_W'(sqy_reg) + DIST_W'(sqz_reg));
    end

    assign res_tag  = t4_reg;
    assign res_dist = dist_reg;
    assign busy     = t2_reg.vld || t3_reg.vld || t4_reg.vld;

endmodule

### sv/rover_table_nearest_match_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rover_table_nearest_match_top
// Rover table with identifier lookup, nearest-anchor join and slot recycling.
// ----------------------------------------------------------------------------
// One request at a time. The table sits in one RAM with a single read port, so
// the scan reads one entry per cycle, then the distance pipeline drains, and the
// S_RESP state decides, writes back and loads the result register. The next
// request can be taken in the same cycle that the result beat appears. A result
// waiting on out_stall holds the next request in the decision state. The table
// needs no clearing after reset: only entries below slots_used are ever read,
// and each of those was written when appended.
// ----------------------------------------------------------------------------
`include "rover_table_nearest_match_top_assert.svh"

module rover_table_nearest_match_top
    import rtnm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [PROX_W-1:0]          cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       action,
    input  logic [ID_W-1:0]            rover_id,
    input  logic signed [COORD_W-1:0]  x_mm,
    input  logic signed [COORD_W-1:0]  y_mm,
    input  logic signed [COORD_W-1:0]  z_mm,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [SLOT_W-1:0]          slot,
    output logic [STATUS_W-1:0]        status,
    output logic signed [COORD_W-1:0]  anchor_x_mm,
    output logic signed [COORD_W-1:0]  anchor_y_mm,
    output logic signed [COORD_W-1:0]  anchor_z_mm
);

    state_t              state_reg, state_next;
    logic [PROX_W-1:0]   prox_reg;
    logic [SQ_W-1:0]     lim_reg;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic [CNT_W-1:0]    scan_cnt_reg;
    logic                rd_vld_reg;
    logic [IDX_W-1:0]    rd_idx_reg;

    logic                req_action_reg;
    logic [ID_W-1:0]     req_id_reg;
    logic [COORD_W-1:0]  req_x_reg, req_y_reg, req_z_reg;

    logic                match_found_reg, free_found_reg, best_found_reg;
    logic [IDX_W-1:0]    match_idx_reg, free_idx_reg, best_idx_reg;
    logic [DIST_W-1:0]   match_dist_reg, best_dist_reg;
    entry_t              match_anc_reg, best_anc_reg;

    logic                out_valid_reg;
    logic [SLOT_W-1:0]   slot_reg;
    status_t             status_reg;
    logic [COORD_W-1:0]  anc_x_reg, anc_y_reg, anc_z_reg;

    logic                accept, rd_issue, resp_fire, out_free;
    entry_t              rd_entry, wr_entry;
    tag_t                res_tag;
    logic [DIST_W-1:0]   res_dist;
    logic                dist_busy;

    status_t             res_status;
    logic [IDX_W-1:0]    res_idx;
    logic                wr_en, show, inc_used;
    logic [COORD_W-1:0]  res_x, res_y, res_z;

    // Table storage
    rtnm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (wr_en && resp_fire),
        .waddr (res_idx),
        .wdata (wr_entry),
        .raddr (scan_cnt_reg[IDX_W-1:0]),
        .rdata (rd_entry)
    );

    // Distance pipeline
    rtnm_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_vld   (rd_vld_reg),
        .rd_idx   (rd_idx_reg),
        .rd_entry (rd_entry),
        .req_id   (req_id_reg),
        .req_x    (req_x_reg),
        .req_y    (req_y_reg),
        .req_z    (req_z_reg),
        .prox     (prox_reg),
        .res_tag  (res_tag),
        .res_dist (res_dist),
        .busy     (dist_busy)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_cnt_reg == used_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!rd_vld_reg && !dist_busy)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        out_free  = !out_valid_reg || !out_stall;
        in_stall  = (state_reg != S_IDLE);
        accept    = (state_reg == S_IDLE) && in_valid;
        rd_issue  = (state_reg == S_SCAN) && (scan_cnt_reg != used_reg);
        resp_fire = (state_reg == S_RESP) && out_free;
    end

    // Decide the outcome from what the scan found
    always_comb
    begin
        res_status = ST_REJECTED;
        res_idx    = '0;
        wr_en      = 1'b0;
        show       = 1'b0;
        inc_used   = 1'b0;
        res_x      = '0;
        res_y      = '0;
        res_z      = '0;
        wr_entry   = '{id: req_id_reg, x: req_x_reg, y: req_y_reg, z: req_z_reg};
        if (req_action_reg)
        begin
            if (match_found_reg)
            begin
                res_status = ST_DELETED;
                res_idx    = match_idx_reg;
                wr_en      = 1'b1;
                wr_entry   = '0;
            end
            else
            begin
                res_status = ST_ABSENT;
            end
        end
        else if (req_id_reg == '0 || req_x_reg == '0 || req_y_reg == '0
                 || req_z_reg == '0)
        begin
            res_status = ST_REJECTED;
        end
        else if (match_found_reg)
        begin
            res_idx = match_idx_reg;
            show    = 1'b1;
            if (match_dist_reg > DIST_W'(lim_reg))
            begin
                res_status = ST_REANCHORED;
                wr_en      = 1'b1;
                res_x      = req_x_reg;
                res_y      = req_y_reg;
                res_z      = req_z_reg;
            end
            else
            begin
                res_status = ST_UPDATED;
                res_x      = match_anc_reg.x;
                res_y      = match_anc_reg.y;
                res_z      = match_anc_reg.z;
            end
        end
        else if (best_found_reg && best_dist_reg <= DIST_W'(lim_reg))
        begin
            res_status = ST_JOINED;
            res_idx    = best_idx_reg;
            show       = 1'b1;
            res_x      = best_anc_reg.x;
            res_y      = best_anc_reg.y;
            res_z      = best_anc_reg.z;
        end
        else if (free_found_reg)
        begin
            res_status = ST_RECYCLED;
            res_idx    = free_idx_reg;
            wr_en      = 1'b1;
            show       = 1'b1;
        end
        else if (used_reg != CNT_W'(TABLE_DEPTH))
        begin
            res_status = ST_APPENDED;
            res_idx    = used_reg[IDX_W-1:0];
            wr_en      = 1'b1;
            show       = 1'b1;
            inc_used   = 1'b1;
        end
        else
        begin
            res_status = ST_FULL;
        end
        if (show && wr_en)
        begin
            res_x = req_x_reg;
            res_y = req_y_reg;
            res_z = req_z_reg;
        end
        used_next = (resp_fire && inc_used) ? (used_reg + 1'b1) : used_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prox_reg      <= PROX_RESET;
            used_reg      <= '0;
            scan_cnt_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            rd_vld_reg <= rd_issue;
            if (cfg_wr_en)
            begin
                prox_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                scan_cnt_reg <= '0;
            end
            else if (rd_issue)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            if (resp_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Scan trackers: first match, first free slot, nearest occupied anchor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            best_found_reg  <= 1'b0;
        end
        else if (accept)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            best_found_reg  <= 1'b0;
        end
        else if (res_tag.vld)
        begin
            if (res_tag.match && !match_found_reg)
            begin
                match_found_reg <= 1'b1;
            end
            if (res_tag.free && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
            if (!res_tag.free)
            begin
                best_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_tag.vld)
        begin
            if (res_tag.match && !match_found_reg)
            begin
                match_idx_reg  <= res_tag.idx;
                match_dist_reg <= res_dist;
                match_anc_reg  <= '{id: req_id_reg, x: res_tag.x, y: res_tag.y,
                                    z: res_tag.z};
            end
            if (res_tag.free && !free_found_reg)
            begin
                free_idx_reg <= res_tag.idx;
            end
            if (!res_tag.free && (!best_found_reg || res_dist < best_dist_reg))
            begin
                best_idx_reg  <= res_tag.idx;
                best_dist_reg <= res_dist;
                best_anc_reg  <= '{id: req_id_reg, x: res_tag.x, y: res_tag.y,
                                   z: res_tag.z};
            end
        end
    end

    // Request, limit and result payload
    always_ff @(posedge clk)
    begin
        lim_reg  <= SQ_W'(prox_reg) * SQ_W'(prox_reg);
        rd_idx_reg <= scan_cnt_reg[IDX_W-1:0];
        if (accept)
        begin
            req_action_reg <= action;
            req_id_reg     <= rover_id;
            req_x_reg      <= x_mm;
            req_y_reg      <= y_mm;
            req_z_reg      <= z_mm;
        end
        if (resp_fire)
        begin
            slot_reg   <= SLOT_W'(res_idx);
            status_reg <= res_status;
            anc_x_reg  <= res_x;
            anc_y_reg  <= res_y;
            anc_z_reg  <= res_z;
        end
    end

    assign out_valid   = out_valid_reg;
    assign slot        = slot_reg;
    assign status      = status_reg;
    assign anchor_x_mm = anc_x_reg;
    assign anchor_y_mm = anc_y_reg;
    assign anchor_z_mm = anc_z_reg;

    `RTNM_ASSERT_IMP(a_used_bound, 1'b1, used_reg <= CNT_W'(TABLE_DEPTH),
        "slot count beyond table depth")
    `RTNM_ASSERT_NXT(a_append_grows, resp_fire && res_status == ST_APPENDED,
        used_reg == $past(used_reg) + 1'b1, "append did not grow slot count")
    `RTNM_ASSERT_IMP(a_write_in_range, resp_fire && wr_en,
        CNT_W'(res_idx) < used_next, "write outside used slots")
    `RTNM_ASSERT_IMP(a_out_from_resp, $rose(out_valid_reg),
        $past(state_reg == S_RESP), "result beat without decision")
    `RTNM_ASSERT_IMP(a_accept_idle, in_valid && !in_stall,
        state_reg == S_IDLE, "request taken while busy")

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rover table with nearest-anchor matching.
// Directed requests cover rejects, update, re-anchor, join, delete, recycle,
// append and a full table; random traffic around a few shared positions then
// runs under several proximity settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top
    import rtnm_pkg::*;
();

    typedef struct {
        logic [SLOT_W-1:0]          slot;
        logic [STATUS_W-1:0]        status;
        logic signed [COORD_W-1:0]  ax;
        logic signed [COORD_W-1:0]  ay;
        logic signed [COORD_W-1:0]  az;
    } outcome_t;

    localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic                      ACT_ADD = 1'b0;
    localparam logic                      ACT_DEL = 1'b1;
    localparam int                        SETTLE_CYCLES = 60;
    localparam int                        HOLD_CYCLES   = 300;
    localparam int                        STALL_LIMIT   = 3000;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [PROX_W-1:0]         cfg_wr_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      action = ACT_ADD;
    logic [ID_W-1:0]           rover_id = '0;
    logic signed [COORD_W-1:0] x_mm = '0;
    logic signed [COORD_W-1:0] y_mm = '0;
    logic signed [COORD_W-1:0] z_mm = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [SLOT_W-1:0]         slot;
    logic [STATUS_W-1:0]       status;
    logic signed [COORD_W-1:0] anchor_x_mm;
    logic signed [COORD_W-1:0] anchor_y_mm;
    logic signed [COORD_W-1:0] anchor_z_mm;

    // Shadow copy of the table
    logic [ID_W-1:0]           tbl_id [TABLE_DEPTH];
    logic signed [COORD_W-1:0] tbl_x  [TABLE_DEPTH];
    logic signed [COORD_W-1:0] tbl_y  [TABLE_DEPTH];
    logic signed [COORD_W-1:0] tbl_z  [TABLE_DEPTH];
    int                        tbl_used = 0;
    logic [PROX_W-1:0]         prox = PROX_RESET;

    outcome_t                  pending_results[$];
    int                        errors = 0;
    bit                        idle_on = 1'b1;
    bit                        long_hold_req = 1'b0;
    int                        stall_left = 0;
    int                        quiet_cycles = 0;

    logic [ID_W-1:0]           id_pool [40];
    logic signed [COORD_W-1:0] centers [6];

    rover_table_nearest_match_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .rover_id    (rover_id),
        .x_mm        (x_mm),
        .y_mm        (y_mm),
        .z_mm        (z_mm),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .slot        (slot),
        .status      (status),
        .anchor_x_mm (anchor_x_mm),
        .anchor_y_mm (anchor_y_mm),
        .anchor_z_mm (anchor_z_mm)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Squared distance to entry i, all ones when any axis is beyond proximity
    function automatic longint unsigned anchor_dist_sq(int i, logic signed [COORD_W-1:0] x,
                                                       logic signed [COORD_W-1:0] y,
                                                       logic signed [COORD_W-1:0] z);
        longint d [3];
        longint unsigned m;
        longint unsigned sum;
        bit far;
        sum = 0;
        far = 1'b0;
        d[0] = longint'(x) - longint'(tbl_x[i]);
        d[1] = longint'(y) - longint'(tbl_y[i]);
        d[2] = longint'(z) - longint'(tbl_z[i]);
        foreach (d[k])
        begin
            m = (d[k] < 0) ? longint'(-d[k]) : longint'(d[k]);
            if (m > longint'(prox))
                far = 1'b1;
            else
                sum += m * m;
        end
        return far ? '1 : sum;
    endfunction

    function automatic void store_entry(int i, logic [ID_W-1:0] id,
                                        logic signed [COORD_W-1:0] x,
                                        logic signed [COORD_W-1:0] y,
                                        logic signed [COORD_W-1:0] z);
        tbl_id[i] = id;
        tbl_x[i]  = x;
        tbl_y[i]  = y;
        tbl_z[i]  = z;
    endfunction

    function automatic outcome_t make_outcome(int i, status_t st, bit show);
        outcome_t o;
        o.slot   = SLOT_W'(i);
        o.status = st;
        o.ax     = show ? tbl_x[i] : '0;
        o.ay     = show ? tbl_y[i] : '0;
        o.az     = show ? tbl_z[i] : '0;
        return o;
    endfunction

    // Apply one request to the shadow table and return its outcome
    function automatic outcome_t apply_request(logic act, logic [ID_W-1:0] id,
                                               logic signed [COORD_W-1:0] x,
                                               logic signed [COORD_W-1:0] y,
                                               logic signed [COORD_W-1:0] z);
        longint unsigned lim;
        longint unsigned d;
        longint unsigned best_d;
        int best;
        bit found;
        lim = longint'(prox) * longint'(prox);
        best = 0;
        best_d = 0;
        found = 1'b0;
        if (act == ACT_DEL)
        begin
            for (int i = 0; i < tbl_used; i++)
                if (tbl_id[i] == id)
                begin
                    store_entry(i, '0, '0, '0, '0);
                    return make_outcome(i, ST_DELETED, 1'b0);
                end
            return make_outcome(0, ST_ABSENT, 1'b0);
        end
        if (id == 0 || x == 0 || y == 0 || z == 0)
            return make_outcome(0, ST_REJECTED, 1'b0);
        for (int i = 0; i < tbl_used; i++)
            if (tbl_id[i] == id)
            begin
                if (anchor_dist_sq(i, x, y, z) > lim)
                begin
                    store_entry(i, id, x, y, z);
                    return make_outcome(i, ST_REANCHORED, 1'b1);
                end
                return make_outcome(i, ST_UPDATED, 1'b1);
            end
        // nearest occupied anchor, lowest index wins ties
        for (int i = 0; i < tbl_used; i++)
        begin
            if (tbl_id[i] == 0)
                continue;
            d = anchor_dist_sq(i, x, y, z);
            if (!found || d < best_d)
            begin
                found = 1'b1;
                best = i;
                best_d = d;
            end
        end
        if (found && best_d <= lim)
            return make_outcome(best, ST_JOINED, 1'b1);
        for (int i = 0; i < tbl_used; i++)
            if (tbl_id[i] == 0)
            begin
                store_entry(i, id, x, y, z);
                return make_outcome(i, ST_RECYCLED, 1'b1);
            end
        if (tbl_used < TABLE_DEPTH)
        begin
            store_entry(tbl_used, id, x, y, z);
            tbl_used++;
            return make_outcome(tbl_used - 1, ST_APPENDED, 1'b1);
        end
        return make_outcome(0, ST_FULL, 1'b0);
    endfunction

    task automatic report_mismatch(string field, longint exp_v, longint got_v);
        $display("ERROR %0t: %s expected %0d got %0d", $realtime, field, exp_v, got_v);
        errors++;
    endtask

    // Drive one request beat and wait for it to be taken
    task automatic send_request(logic act, logic [ID_W-1:0] id,
                                logic signed [COORD_W-1:0] x,
                                logic signed [COORD_W-1:0] y,
                                logic signed [COORD_W-1:0] z);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        rover_id <= id;
        x_mm     <= x;
        y_mm     <= y;
        z_mm     <= z;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(apply_request(act, id, x, y, z));
    endtask

    // Drop valid and wait until every result is back and the block settles
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_proximity(logic [PROX_W-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        prox = value;
    endtask

    function automatic logic signed [COORD_W-1:0] near_coord(logic signed [COORD_W-1:0] c);
        longint span;
        span = (prox < 4) ? 3 : longint'(prox) * 3 / 2;
        if ($urandom_range(0, 4) == 0)
            return c;
        return COORD_W'(longint'(c) + longint'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic signed [COORD_W-1:0] wide_coord();
        return COORD_W'({$urandom, $urandom});
    endfunction

    // Rejects, update at the limit, re-anchor, join at the limit, delete, recycle
    task automatic test_directed();
        write_proximity(PROX_W'(1000));
        send_request(ACT_ADD, '0, 34'sd5, 34'sd5, 34'sd5);
        send_request(ACT_ADD, 32'd7, 34'sd0, 34'sd5, 34'sd5);
        send_request(ACT_ADD, 32'd7, 34'sd5, 34'sd0, 34'sd5);
        send_request(ACT_ADD, 32'd7, 34'sd5, 34'sd5, 34'sd0);
        send_request(ACT_ADD, 32'd7, 34'sd1000, 34'sd1000, 34'sd1000);
        send_request(ACT_ADD, 32'd7, 34'sd2000, 34'sd1000, 34'sd1000);
        send_request(ACT_ADD, 32'd7, 34'sd2001, 34'sd1000, 34'sd1000);
        send_request(ACT_ADD, '1, 34'sd1001, 34'sd1000, 34'sd1000);
        send_request(ACT_ADD, '1, C_MAX, C_MIN, C_MAX);
        send_request(ACT_ADD, 32'h5555_AAAA, C_MIN, C_MAX, -34'sd1);
        send_request(ACT_ADD, 32'hAAAA_5555, C_MIN, C_MAX, -34'sd1);
        send_request(ACT_DEL, 32'd7, 34'sd0, 34'sd0, 34'sd0);
        send_request(ACT_DEL, 32'd7, 34'sd0, 34'sd0, 34'sd0);
        send_request(ACT_DEL, '0, C_MAX, C_MAX, C_MAX);
        send_request(ACT_ADD, 32'd9, 34'sd5000000, 34'sd5000000, 34'sd5000000);
        send_request(ACT_ADD, 32'd10, 34'sd5000000, 34'sd5000000, 34'sd5000600);
        send_request(ACT_ADD, 32'd11, 34'sd5000000, 34'sd5000000, 34'sd5000300);
        send_request(ACT_DEL, '1, C_MIN, C_MIN, C_MIN);
    endtask

    // Append distinct rovers at scattered positions until the table is full and then past it
    task automatic test_fill_table();
        write_proximity('0);
        for (int i = 0; i < TABLE_DEPTH + 3; i++)
            send_request(ACT_ADD, 32'h1000_0000 + i, 34'sd7000000 + i * 1000,
                         -34'sd7000000, 34'sd123);
    endtask

    // Hold the result side long enough to back up the input, then pause
    task automatic test_backpressure();
        long_hold_req = 1'b1;
        for (int i = 0; i < 6; i++)
            send_request(ACT_ADD, id_pool[i], near_coord(centers[0]),
                         near_coord(centers[0]), near_coord(centers[0]));
        wait_drained();
    endtask

    task automatic test_random_traffic(logic [PROX_W-1:0] value, int count);
        int pick;
        int c;
        write_proximity(value);
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            c = $urandom_range(0, 5);
            if (pick < 55)
                send_request(ACT_ADD, id_pool[$urandom_range(0, 39)], near_coord(centers[c]),
                             near_coord(centers[c]), near_coord(centers[c]));
            else if (pick < 72)
                send_request(ACT_ADD, $urandom, near_coord(centers[c]),
                             near_coord(centers[c]), near_coord(centers[c]));
            else if (pick < 88)
                send_request(ACT_DEL, id_pool[$urandom_range(0, 39)],
                             wide_coord(), wide_coord(), wide_coord());
            else if (pick < 93)
                send_request(ACT_DEL, ($urandom_range(0, 1) == 0) ? '0 : $urandom,
                             wide_coord(), wide_coord(), wide_coord());
            else if (pick < 97)
                send_request(ACT_ADD, $urandom, wide_coord(), wide_coord(), wide_coord());
            else
                send_request(ACT_ADD, ($urandom_range(0, 1) == 0) ? '0 : id_pool[c],
                             near_coord(centers[c]), '0, near_coord(centers[c]));
        end
    endtask

    // Random stall bursts and the long hold on the result side
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                stall_left = HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 15);
            out_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    // Check each result beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("ERROR %0t: result with nothing pending", $realtime);
                errors++;
            end
            else
            begin
                outcome_t e;
                e = pending_results.pop_front();
                if (slot !== e.slot)
                    report_mismatch("slot", e.slot, slot);
                if (status !== e.status)
                    report_mismatch("status", e.status, status);
                if (anchor_x_mm !== e.ax)
                    report_mismatch("anchor_x_mm", e.ax, anchor_x_mm);
                if (anchor_y_mm !== e.ay)
                    report_mismatch("anchor_y_mm", e.ay, anchor_y_mm);
                if (anchor_z_mm !== e.az)
                    report_mismatch("anchor_z_mm", e.az, anchor_z_mm);
            end
        end
    end

    // Abort when no beat moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        foreach (tbl_id[i])
            store_entry(i, '0, '0, '0, '0);
        foreach (id_pool[i])
            id_pool[i] = (i == 0) ? '1 : $urandom;
        foreach (centers[i])
            centers[i] = COORD_W'(longint'($urandom) * 2 - 64'sd4294967296);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_traffic(PROX_W'(16777215), 150);
        test_random_traffic(PROX_RESET, 150);
        test_fill_table();
        test_backpressure();
        test_random_traffic('0, 100);
        idle_on = 1'b0;
        test_random_traffic(PROX_W'(1000), 190);

        wait_drained();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/rtnm_pkg.sv
sv/rtnm_ram.sv
sv/rtnm_dist.sv
sv/rover_table_nearest_match_top.sv
test/tb_top.sv
